[hdl/rpbr_pkg.sv]
`default_nettype none

package rpbr_pkg;

  localparam int MAX_LEN_DEF = 64;
  localparam int VAL_W       = 32;
  localparam int POS_W       = 6;

  typedef logic signed [VAL_W-1:0] value_t;
  typedef logic [POS_W-1:0]        pos_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] item_value;
    logic                    item_last;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0]        removal_position;
    logic [POS_W-1:0]        source_index;
    logic signed [VAL_W-1:0] removed_value;
    logic                    run_end;
  } out_item_t;

  // Contents of one cell of the sorted chain.
  typedef struct packed {
    value_t value;
    pos_t   src;
    pos_t   cnt;
  } entry_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic   load_en;
    logic   drain_en;
    value_t new_value;
    pos_t   new_src;
  } cell_ctrl_t;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_t;

endpackage

`default_nettype wire

[hdl/rpbr_cell.sv]
`default_nettype none

module rpbr_cell
  import rpbr_pkg::*;
#(
  parameter int CELL_IDX = 0,
  parameter int CNT_W    = 7
) (
  input  wire logic             clk,
  input  wire cell_ctrl_t       ctrl,
  input  wire logic [CNT_W-1:0] fill,
  input  wire entry_t           left_entry,
  input  wire logic             left_sel,
  input  wire entry_t           right_entry,
  output entry_t                entry,
  output logic                  sel
);

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(CELL_IDX);

  entry_t entry_r;
  entry_t entry_nxt;
  logic   occupied;
  logic   take_new;

  // The chain is kept in ascending order, so sel is low on a prefix of the
  // chain and high from the insertion point onward.
  assign occupied = (MY_IDX < fill);
  assign sel      = !occupied || (entry_r.value > ctrl.new_value);
  assign take_new = sel && !left_sel;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.load_en) begin
      if (take_new) begin
        entry_nxt.value = ctrl.new_value;
        entry_nxt.src   = ctrl.new_src;
        // Every occupied cell at or after this one holds a greater value.
        entry_nxt.cnt   = POS_W'(fill - MY_IDX);
      end else if (sel) begin
        entry_nxt = left_entry;
      end
    end else if (ctrl.drain_en) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

`default_nettype wire

[hdl/removal_position_by_rank_core.sv]
`default_nettype none

// Channel  Direction  Payload      Handshake
// in_      input      in_item_t    in_valid / in_ready
// out_     output     out_item_t   out_valid / out_ready
//
// Loading takes one cycle per item; an item marked last, or the item that
// fills MAX_LEN cells, ends the list. The block then presents one result per
// cycle from the head of the cell chain, as long as out_ready is high. No input
// item is taken while results drain. Reset is synchronous and active low
// and empties the chain at once. A stalled result holds in the head cell
// until out_ready is seen.

module removal_position_by_rank_core
  import rpbr_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_item
);

  // The fill count must be able to hold MAX_LEN itself.
  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam logic [CNT_W-1:0] LEN_MAX = CNT_W'(MAX_LEN);
  localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0] remain_r, remain_nxt;
  logic [CNT_W-1:0] fill_inc;
  logic             in_acc;
  logic             out_acc;
  cell_ctrl_t       ctrl;

  entry_t ent   [MAX_LEN];
  logic   sel   [MAX_LEN];
  entry_t left  [MAX_LEN];
  logic   lsel  [MAX_LEN];
  entry_t right [MAX_LEN];

  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid && out_ready;
  assign fill_inc = fill_r + ONE;

  // Every cell sees the arriving item in the same cycle. Cells holding a
  // greater value move one place toward the tail, and the first of them
  // takes the new item, so the chain stays sorted with ties in arrival order.
  // During draining the whole chain moves one place toward the head.
  always_comb begin
    ctrl.load_en   = in_acc;
    ctrl.drain_en  = out_acc;
    ctrl.new_value = in_item.item_value;
    ctrl.new_src   = POS_W'(fill_r);
  end

  for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign left[k] = ent[k];
      assign lsel[k] = 1'b0;
    end else begin : g_body
      assign left[k] = ent[k-1];
      assign lsel[k] = sel[k-1];
    end
    if (k == MAX_LEN - 1) begin : g_tail
      assign right[k] = ent[k];
    end else begin : g_inner
      assign right[k] = ent[k+1];
    end

    rpbr_cell #(
      .CELL_IDX (k),
      .CNT_W    (CNT_W)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .fill        (fill_r),
      .left_entry  (left[k]),
      .left_sel    (lsel[k]),
      .right_entry (right[k]),
      .entry       (ent[k]),
      .sel         (sel[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_LOAD;
      fill_r   <= '0;
      remain_r <= '0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      remain_r <= remain_nxt;
    end
  end

  // The head cell always holds the smallest element left, so it is the
  // next result; run_end marks the one left last.
  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    remain_nxt = remain_r;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_acc) begin
          if (in_item.item_last || (fill_inc == LEN_MAX)) begin
            state_nxt  = ST_DRAIN;
            fill_nxt   = '0;
            remain_nxt = fill_inc;
          end else begin
            fill_nxt = fill_inc;
          end
        end
      end
      ST_DRAIN: begin
        out_valid = 1'b1;
        if (out_acc) begin
          remain_nxt = remain_r - ONE;
          if (remain_r == ONE) begin
            state_nxt = ST_LOAD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_comb begin
    out_item.removal_position = ent[0].cnt;
    out_item.source_index     = ent[0].src;
    out_item.removed_value    = ent[0].value;
    out_item.run_end          = (remain_r == ONE);
  end

  // Loading and draining never overlap.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input and result channels active together");

  // The fill count never reaches the chain length while loading.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r < LEN_MAX)
    else $error("fill count out of range");

  // An item marked last is followed by results.
  a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_item.item_last) |=> out_valid)
    else $error("last item did not start draining");

  // The final result returns the block to loading.
  a_end_reloads: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_item.run_end) |=> (in_ready && !out_valid))
    else $error("block did not return to loading after the final result");

  // A drain never runs with nothing left.
  a_remain_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (remain_r != '0))
    else $error("result presented with an empty chain");

endmodule

`default_nettype wire

[dv/removal_position_by_rank_core_tb.sv]
`timescale 1ns / 100ps

// Testbench for the removal-position-by-rank core.
//
// Lists of signed values stream in on the input channel, one value per item.
// A list ends on an item with item_last set, or on the item that fills the
// list to the full length. The core then drains one result per element, in
// ascending order of value with ties going to the lower original index. Each
// result carries the number of earlier elements that are strictly greater.
// The testbench keeps its own copy of the list being loaded. It turns each
// finished list into a queue of the removals it expects, and a checker
// process compares every accepted result with the head of that queue.

module removal_position_by_rank_core_tb;
  import rpbr_pkg::*;

  localparam int     LIST_MAX        = MAX_LEN_DEF;
  localparam int     HOLD_OFF_CYCLES = 300;
  localparam int     DRAIN_LIMIT     = 20000;
  localparam value_t VAL_MIN         = value_t'(32'h8000_0000);
  localparam value_t VAL_MAX         = value_t'(32'h7fff_ffff);

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  // Mirror of the list that the core is loading: values in arrival order and,
  // for each, how many earlier values were strictly greater when it arrived.
  value_t    loaded_values[$];
  pos_t      greater_before[$];

  // Removals still owed by the core, in the order they must come out.
  out_item_t removals_due[$];

  int err_count     = 0;

  // Percent chance per cycle that the sender or the receiver idles.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Each bump of hold_token asks the receiver for one long hold-off.
  int hold_token    = 0;
  int hold_seen     = 0;
  int hold_left     = 0;

  removal_position_by_rank_core #(
    .MAX_LEN(LIST_MAX)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the core hangs on either channel.
  initial begin
    #2ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Adds one accepted element to the mirrored list. When the element closes
  // the list, the removals are ranked and queued in the order the core must
  // emit them, and the mirror is emptied for the next list.
  function automatic void rank_removals(input value_t v, input logic last);
    out_item_t ordered[LIST_MAX];
    int        greater;
    int        n;
    int        rank;
    int        i;
    int        j;
    greater = 0;
    foreach (loaded_values[k]) begin
      if (loaded_values[k] > v) greater++;
    end
    loaded_values  = {loaded_values, v};
    greater_before = {greater_before, pos_t'(greater)};
    n = loaded_values.size();
    // A full list closes whatever its last bit says.
    if (!last && n < LIST_MAX) return;
    for (i = 0; i < n; i++) begin
      rank = 0;
      for (j = 0; j < n; j++) begin
        // Equal values are ranked by original index, so ties never swap.
        if (loaded_values[i] > loaded_values[j] ||
            (loaded_values[i] == loaded_values[j] && j < i)) rank++;
      end
      ordered[rank] = '{removal_position: greater_before[i],
                        source_index:     pos_t'(i),
                        removed_value:    loaded_values[i],
                        run_end:          (rank == n - 1)};
    end
    for (i = 0; i < n; i++) removals_due = {removals_due, ordered[i]};
    loaded_values.delete();
    greater_before.delete();
  endfunction

  function automatic void check_removal(input out_item_t got);
    out_item_t want;
    if (removals_due.size() == 0) begin
      $error("unexpected result: removal_position %0d source_index %0d removed_value %0d",
             got.removal_position, got.source_index, got.removed_value);
      err_count++;
      return;
    end
    want = removals_due.pop_front();
    if (got.removal_position !== want.removal_position) begin
      $error("removal_position: expected %0d, got %0d",
             want.removal_position, got.removal_position);
      err_count++;
    end
    if (got.source_index !== want.source_index) begin
      $error("source_index: expected %0d, got %0d", want.source_index, got.source_index);
      err_count++;
    end
    if (got.removed_value !== want.removed_value) begin
      $error("removed_value: expected %0d, got %0d", want.removed_value, got.removed_value);
      err_count++;
    end
    if (got.run_end !== want.run_end) begin
      $error("run_end: expected %0d, got %0d", want.run_end, got.run_end);
      err_count++;
    end
  endfunction

  // Receiver side. Outputs are sampled at the edge before any update of this
  // step lands, so a result counts as taken when out_valid and out_ready were
  // both high going into the edge. The next out_ready is chosen afterward.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_removal(out_item);
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Values are drawn from a mix: full-range values exercise every bit, a
  // narrow band around zero produces plenty of ties, and the extremes show up
  // now and then.
  function automatic value_t pick_value();
    int unsigned mode;
    mode = $urandom_range(99);
    if (mode < 50) return value_t'($urandom());
    if (mode < 88) return value_t'(int'($urandom_range(8)) - 4);
    case ($urandom_range(3))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return value_t'(0);
      default: return value_t'(-1);
    endcase
  endfunction

  // Offers one item and waits until it is taken. Valid stays high on return,
  // so back-to-back items go out without a gap unless the sender idles.
  task automatic send_item(input value_t v, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{item_value: v, item_last: last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    rank_removals(v, last);
  endtask

  // Sends a whole list with the last bit on its final element.
  task automatic send_list(input value_t vals[$]);
    foreach (vals[k]) send_item(vals[k], k == vals.size() - 1);
  endtask

  // A single-element list and a list with both extremes, zero and minus one.
  task automatic test_extremes();
    send_list({VAL_MIN});
    send_list({VAL_MAX, VAL_MIN, value_t'(0), value_t'(-1), value_t'(1)});
  endtask

  // Repeated values: equal elements must never count as greater and must come
  // out in their original order.
  task automatic test_ties();
    send_list({value_t'(5), value_t'(5), value_t'(5), value_t'(-3), value_t'(5),
               value_t'(-3)});
  endtask

  // Strictly descending input gives the largest greater-before counts;
  // ascending input gives all zeros.
  task automatic test_orderings();
    send_list({value_t'(100), value_t'(50), value_t'(7), value_t'(0), value_t'(-1),
               value_t'(-9), value_t'(-300), VAL_MIN});
    send_list({VAL_MIN, value_t'(-2), value_t'(3), VAL_MAX});
  endtask

  // A list that fills every cell: once with no last bit at all, so the full
  // length alone ends it, and once with the last bit on the final element.
  task automatic test_full_list();
    int k;
    for (k = 1; k <= LIST_MAX; k++) send_item(pick_value(), 1'b0);
    for (k = 1; k <= LIST_MAX; k++) send_item(pick_value(), k == LIST_MAX);
  endtask

  // Random lists, mostly short so that many lists complete, with an
  // occasional long one. A list that reaches the full length carries a
  // random last bit on its final element.
  task automatic test_random_lists(input int n_items);
    int   sent;
    int   len;
    int   k;
    logic last_bit;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) len = $urandom_range(LIST_MAX, 13);
      else len = $urandom_range(12, 1);
      for (k = 1; k <= len; k++) begin
        last_bit = (k == len);
        if (k == LIST_MAX) last_bit = 1'($urandom_range(1));
        send_item(pick_value(), last_bit);
      end
      sent += len;
    end
  endtask

  // The receiver holds off for a long stretch while two long lists are
  // offered back to back. The first list's results back up in the core, and
  // the second list has to wait at the input until the receiver lets go.
  task automatic test_backpressure();
    int k;
    hold_token++;
    for (k = 1; k <= 40; k++) send_item(pick_value(), k == 40);
    for (k = 1; k <= 30; k++) send_item(pick_value(), k == 30);
  endtask

  initial begin
    int k;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Slow receiver, mostly eager sender.
    send_idle_pct = 9;
    recv_idle_pct = 65;
    test_extremes();
    test_ties();
    test_orderings();
    test_random_lists(80);

    // Slow sender, mostly eager receiver.
    send_idle_pct = 65;
    recv_idle_pct = 9;
    test_full_list();
    test_random_lists(80);

    // Neither side idles, apart from the forced hold-off.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random_lists(80);

    in_valid <= 1'b0;
    for (k = 0; k < DRAIN_LIMIT && removals_due.size() != 0; k++) @(posedge clk);
    repeat (20) @(posedge clk);
    if (removals_due.size() != 0) begin
      $error("%0d expected results never arrived", removals_due.size());
      err_count++;
    end
    if (err_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
